FILE: rtl/ping_round_trip_tracker_macros.svh
`ifndef PING_ROUND_TRIP_TRACKER_MACROS_SVH
`define PING_ROUND_TRIP_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF
`define PRTT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PRTT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRTT_ASSERT(name, clk, rst, prop, msg)
`define PRTT_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

FILE: rtl/prtt_pkg.sv
package prtt_pkg;

   localparam logic [1:0]  CMD_RECORD        = 2'd0;
   localparam logic [1:0]  CMD_RECEIVE       = 2'd1;
   localparam logic [1:0]  CMD_TICK          = 2'd2;
   localparam logic [7:0]  ECHO_REPLY_TYPE   = 8'd0;
   localparam logic [15:0] MIN_MESSAGE_BYTES = 16'd8;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] peer_address;
      logic [7:0]  message_type;
      logic [15:0] message_length;
      logic [15:0] ping_identifier;
      logic [15:0] ping_sequence;
   } req_type;

   typedef struct packed {
      logic [31:0] reply_address;
      logic [15:0] reply_identifier;
      logic [15:0] reply_sequence;
      logic [31:0] round_trip_ms;
      logic        matched;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic compare;
      logic execute;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic is_reply;
   } stat_type;

endpackage

FILE: rtl/prtt_datapath.sv
module prtt_datapath #(
   parameter int TABLE_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  prtt_pkg::req_type req_data,
   input  prtt_pkg::cmd_type cmd,
   output prtt_pkg::stat_type stat,
   output prtt_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   prtt_pkg::req_type       req_ff;
   prtt_pkg::rsp_type       rsp_ff;
   prtt_pkg::rsp_type       rsp_in;
   logic [TABLE_DEPTH-1:0]  used_ff;
   logic [TABLE_DEPTH-1:0]  used_in;
   logic [TABLE_DEPTH-1:0]  hit_ff;
   logic [TABLE_DEPTH-1:0]  free_ff;
   logic [31:0]             count_ff;
   logic [31:0]             count_in;
   logic [31:0]             time_rd_ff;
   logic                    matched_ff;
   logic [15:0]             slot_id_ff  [TABLE_DEPTH];
   logic [15:0]             slot_seq_ff [TABLE_DEPTH];
   logic [31:0]             sent_mem    [TABLE_DEPTH];
   logic [IDX_W-1:0]        hit_idx;
   logic                    any_hit;
   logic [IDX_W-1:0]        free_idx;
   logic                    any_free;
   logic [IDX_W-1:0]        wr_idx;
   logic                    is_reply;
   logic                    do_record;
   logic                    do_reply;

   assign is_reply = (req_ff.command == prtt_pkg::CMD_RECEIVE)
                     && (req_ff.message_length >= prtt_pkg::MIN_MESSAGE_BYTES)
                     && (req_ff.message_type == prtt_pkg::ECHO_REPLY_TYPE);
   assign stat.is_reply = is_reply;
   assign do_record = cmd.execute && (req_ff.command == prtt_pkg::CMD_RECORD);
   assign do_reply  = cmd.execute && is_reply;

   // lowest set bit wins
   always_comb begin
      hit_idx  = '0;
      any_hit  = 1'b0;
      free_idx = '0;
      any_free = 1'b0;
      for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
         if (hit_ff[k]) begin
            hit_idx = IDX_W'(k);
            any_hit = 1'b1;
         end
         if (free_ff[k]) begin
            free_idx = IDX_W'(k);
            any_free = 1'b1;
         end
      end
   end

   assign wr_idx = any_free ? free_idx : '0;

   always_comb begin
      used_in = used_ff;
      if (do_record) begin
         used_in[wr_idx] = 1'b1;
      end else if (do_reply && any_hit) begin
         used_in[hit_idx] = 1'b0;
      end
   end

   assign count_in = (cmd.execute && (req_ff.command == prtt_pkg::CMD_TICK))
                     ? count_ff + 32'd1 : count_ff;

   always_comb begin
      rsp_in.reply_address    = req_ff.peer_address;
      rsp_in.reply_identifier = req_ff.ping_identifier;
      rsp_in.reply_sequence   = req_ff.ping_sequence;
      rsp_in.round_trip_ms    = matched_ff ? count_ff - time_rd_ff : 32'd0;
      rsp_in.matched          = matched_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         count_ff <= '0;
      end else begin
         used_ff  <= used_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.compare) begin
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            hit_ff[k] <= used_ff[k] && (slot_id_ff[k] == req_ff.ping_identifier)
                         && (slot_seq_ff[k] == req_ff.ping_sequence);
         end
         free_ff <= ~used_ff;
      end
      if (do_record) begin
         slot_id_ff[wr_idx]  <= req_ff.ping_identifier;
         slot_seq_ff[wr_idx] <= req_ff.ping_sequence;
      end
      if (do_reply) begin
         matched_ff <= any_hit;
      end
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_record) begin
         sent_mem[wr_idx] <= count_ff;
      end
      if (do_reply) begin
         time_rd_ff <= sent_mem[hit_idx];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/prtt_ctrl.sv
module prtt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  prtt_pkg::stat_type stat,
   output prtt_pkg::cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_COMPARE = 2'd1;
   localparam logic [1:0] ST_EXECUTE = 2'd2;
   localparam logic [1:0] ST_OUTPUT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = ST_EXECUTE;
         end
         ST_EXECUTE: begin
            cmd.execute = 1'b1;
            state_in    = stat.is_reply ? ST_OUTPUT : ST_IDLE;
         end
         ST_OUTPUT: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/ping_round_trip_tracker.sv
// Steps: records, ticks and ignored words pass accept, tag compare and table update;
//   an echo reply adds output load, held while the last result waits; one word at a time.
// Result: an echo reply shows its result after acceptance, compare, table update with
//   send time read, and output load; ticks and records give no result.
// Reset: synchronous; clears the slot used bits, the millisecond count and the control.
`include "ping_round_trip_tracker_macros.svh"

module ping_round_trip_tracker #(
   parameter int TABLE_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  prtt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output prtt_pkg::rsp_type rsp_data
);

   prtt_pkg::cmd_type  cmd;
   prtt_pkg::stat_type stat;

   prtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   prtt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   `PRTT_ASSERT(a_cmd_onehot, clock, reset, $onehot0(cmd), "more than one datapath command")
   `PRTT_ASSERT(a_accept_compare, clock, reset, (req_valid && req_ready) |=> cmd.compare,
                "compare does not follow acceptance")
   `PRTT_ASSERT(a_no_overwrite, clock, reset, cmd.load |-> (!rsp_valid || rsp_ready),
                "pending result overwritten")
   `PRTT_ASSERT(a_unmatched_zero, clock, reset,
                (rsp_valid && !rsp_data.matched) |-> (rsp_data.round_trip_ms == 32'd0),
                "unmatched reply with nonzero round trip")

endmodule
